// ===== design/shared_array_double_stack_unit_assert.svh =====
// Assertion macros for the two-stack unit.
// Used by the top level only; needs no package.
`ifndef SHARED_ARRAY_DOUBLE_STACK_UNIT_ASSERT_SVH
`define SHARED_ARRAY_DOUBLE_STACK_UNIT_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define SADS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("two-stack unit: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define SADS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("two-stack unit: next-cycle check failed");

`endif

// ===== design/sads_pkg.sv =====
// Package for the two-stack unit: action and status codes, field widths,
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package sads_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int ACT_W = 3;
    localparam int KEY_W = 32;
    localparam int STS_W = 2;
    localparam int OCC_W = 7;

    localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SIZE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LIST  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

    localparam logic [STS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic exec;
        logic list_start;
        logic list_emit;
    } sads_cmd_t;

    typedef struct packed {
        logic out_free;
        logic sel_empty;
        logic last_entry;
    } sads_sts_t;

endpackage

// ===== design/sads_req_if.sv =====
// Request channel of the two-stack unit: valid/ready plus request fields.
// Depends on sads_pkg.
`timescale 1ns / 1ps

interface sads_req_if import sads_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic                    stack_select;
    logic signed [KEY_W-1:0] key_value;

    modport source (output valid, action, stack_select, key_value, input ready);
    modport sink (input valid, action, stack_select, key_value, output ready);
endinterface

// ===== design/sads_rsp_if.sv =====
// Result channel of the two-stack unit: valid/ready plus result fields.
// Depends on sads_pkg.
`timescale 1ns / 1ps

interface sads_rsp_if import sads_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STS_W-1:0]        status;
    logic signed [KEY_W-1:0] entry_value;
    logic [OCC_W-1:0]        occupancy;
    logic                    last_result;

    modport source (output valid, status, entry_value, occupancy, last_result, input ready);
    modport sink (input valid, status, entry_value, occupancy, last_result, output ready);
endinterface

// ===== design/sads_ctrl.sv =====
// Controller of the two-stack unit: accepts requests and sequences list output.
// Depends on sads_pkg.
`timescale 1ns / 1ps

module sads_ctrl import sads_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [ACT_W-1:0] req_action,
    output logic             req_ready,
    input  sads_sts_t        sts,
    output sads_cmd_t        cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign req_ready = (state_reg == S_IDLE) && sts.out_free;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd.exec       = 1'b0;
        cmd.list_start = 1'b0;
        cmd.list_emit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((req_action == ACT_LIST) && !sts.sel_empty)
                    begin
                        cmd.list_start = 1'b1;
                        state_next     = S_LIST;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            S_LIST:
            begin
                if (sts.out_free)
                begin
                    cmd.list_emit = 1'b1;
                    if (sts.last_entry)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/sads_dp.sv =====
// Datapath of the two-stack unit: shared entry memory, stack counts,
// list pointer and result register. Depends on sads_pkg.
`timescale 1ns / 1ps

module sads_dp import sads_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [ACT_W-1:0]        req_action,
    input  logic                    req_stack_select,
    input  logic signed [KEY_W-1:0] req_key_value,
    input  sads_cmd_t               cmd,
    output sads_sts_t               sts,
    input  logic                    rsp_ready,
    output logic                    rsp_valid,
    output logic [STS_W-1:0]        rsp_status,
    output logic signed [KEY_W-1:0] rsp_entry_value,
    output logic [OCC_W-1:0]        rsp_occupancy,
    output logic                    rsp_last_result
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rdata_reg;

    logic [CNT_W-1:0]  lower_reg, lower_next;
    logic [CNT_W-1:0]  upper_reg, upper_next;
    logic [CNT_W-1:0]  remain_reg;
    logic [ADDR_W-1:0] ptr_reg;
    logic              list_upper_reg;
    logic              out_valid_reg;

    logic [STS_W-1:0]        status_reg;
    logic signed [KEY_W-1:0] entry_reg;
    logic [OCC_W-1:0]        occ_reg;
    logic                    last_reg;

    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  total_next;
    logic [CNT_W-1:0]  sel_cnt;
    logic [CNT_W-1:0]  up_push_w;
    logic [CNT_W-1:0]  up_start_w;
    logic [CNT_W-1:0]  lo_start_w;
    logic [STS_W-1:0]  res_status;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] step_addr;
    logic              load;

    assign total      = lower_reg + upper_reg;
    assign total_next = lower_next + upper_next;
    assign sel_cnt    = req_stack_select ? upper_reg : lower_reg;
    assign up_push_w  = DEPTH_C - ONE_C - upper_reg;
    assign up_start_w = DEPTH_C - upper_reg;
    assign lo_start_w = lower_reg - ONE_C;

    assign sts.out_free   = !out_valid_reg || rsp_ready;
    assign sts.sel_empty  = (sel_cnt == '0);
    assign sts.last_entry = (remain_reg == ONE_C);

    always_comb
    begin
        lower_next = lower_reg;
        upper_next = upper_reg;
        wr_en      = 1'b0;
        wr_addr    = lower_reg[ADDR_W-1:0];
        res_status = ST_DONE;
        if (cmd.exec)
        begin
            unique case (req_action)
                ACT_PUSH:
                begin
                    if (total >= DEPTH_C)
                    begin
                        res_status = ST_FULL;
                    end
                    else if (req_stack_select)
                    begin
                        upper_next = upper_reg + ONE_C;
                        wr_en      = 1'b1;
                        wr_addr    = up_push_w[ADDR_W-1:0];
                    end
                    else
                    begin
                        lower_next = lower_reg + ONE_C;
                        wr_en      = 1'b1;
                    end
                end
                ACT_POP:
                begin
                    if (sel_cnt == '0)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else if (req_stack_select)
                    begin
                        upper_next = upper_reg - ONE_C;
                    end
                    else
                    begin
                        lower_next = lower_reg - ONE_C;
                    end
                end
                ACT_LIST:
                begin
                    res_status = ST_EMPTY;
                end
                ACT_CLEAR:
                begin
                    lower_next = '0;
                    upper_next = '0;
                end
                default:
                begin
                    res_status = ST_DONE;
                end
            endcase
        end
    end

    assign step_addr = list_upper_reg ? (ptr_reg + ADDR_W'(1)) : (ptr_reg - ADDR_W'(1));
    assign rd_en     = cmd.list_start || cmd.list_emit;
    assign load      = cmd.exec || cmd.list_emit;

    always_comb
    begin
        if (cmd.list_start)
        begin
            rd_addr = req_stack_select ? up_start_w[ADDR_W-1:0] : lo_start_w[ADDR_W-1:0];
        end
        else
        begin
            rd_addr = step_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req_key_value;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg      <= '0;
            upper_reg      <= '0;
            remain_reg     <= '0;
            ptr_reg        <= '0;
            list_upper_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            if (rd_en)
            begin
                ptr_reg <= rd_addr;
            end
            if (cmd.list_start)
            begin
                remain_reg     <= sel_cnt;
                list_upper_reg <= req_stack_select;
            end
            else if (cmd.list_emit)
            begin
                remain_reg <= remain_reg - ONE_C;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= res_status;
            entry_reg  <= '0;
            occ_reg    <= OCC_W'(total_next);
            last_reg   <= 1'b1;
        end
        else if (cmd.list_emit)
        begin
            status_reg <= ST_DONE;
            entry_reg  <= rdata_reg;
            occ_reg    <= OCC_W'(total);
            last_reg   <= (remain_reg == ONE_C);
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp_status      = status_reg;
    assign rsp_entry_value = entry_reg;
    assign rsp_occupancy   = occ_reg;
    assign rsp_last_result = last_reg;

endmodule

// ===== design/shared_array_double_stack_unit.sv =====
// Top level of the two-stack unit: joins controller and datapath to the channels.
// Depends on sads_pkg, sads_req_if, sads_rsp_if, sads_ctrl, sads_dp and the assert header.
//
//   channel  direction  fields
//   req      in         action, stack_select, key_value
//   rsp      out        status, entry_value, occupancy, last_result
//
// Push, pop, size, clear and listing an empty stack give one result each and may
// follow each other in consecutive cycles while results are taken. Listing a stack
// of n entries first reads the first entry from the single memory read port, then
// gives one entry per cycle while results are taken. Reset clears both counts at
// once; the entry memory is not cleared. A stalled result holds the result register
// and blocks new requests until taken.
`timescale 1ns / 1ps
`include "shared_array_double_stack_unit_assert.svh"

module shared_array_double_stack_unit import sads_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sads_req_if.sink    req,
    sads_rsp_if.source  rsp
);

    sads_cmd_t cmd;
    sads_sts_t sts;

    sads_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_ready  (req.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    sads_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_action       (req.action),
        .req_stack_select (req.stack_select),
        .req_key_value    (req.key_value),
        .cmd              (cmd),
        .sts              (sts),
        .rsp_ready        (rsp.ready),
        .rsp_valid        (rsp.valid),
        .rsp_status       (rsp.status),
        .rsp_entry_value  (rsp.entry_value),
        .rsp_occupancy    (rsp.occupancy),
        .rsp_last_result  (rsp.last_result)
    );

    `SADS_ASSERT_NOW(a_occ_bound, clk, rst_n, rsp.valid, rsp.occupancy <= OCC_W'(DEPTH))
    `SADS_ASSERT_NOW(a_mid_list_done, clk, rst_n, rsp.valid && !rsp.last_result, rsp.status == ST_DONE)
    `SADS_ASSERT_NOW(a_no_accept_in_list, clk, rst_n, cmd.list_emit, !req.ready)
    `SADS_ASSERT_NEXT(a_list_holds_req, clk, rst_n, cmd.list_start, !req.ready)

endmodule
